>>> rtl/lzw_pkg.sv
`timescale 1ns / 1ps
package lzw_pkg;
   localparam int CODE_BITS  = 12;
   localparam int BYTE_BITS  = 8;
   localparam int KEY_BITS   = CODE_BITS + BYTE_BITS;
   localparam int DICT_DEPTH = 1 << CODE_BITS;
   localparam logic [CODE_BITS-1:0] STOP_CODE  = {CODE_BITS{1'b1}};
   localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(256);
   localparam int RSP_BITS   = ((CODE_BITS + 7) / 8) * 8;

   // controller to datapath
   typedef struct packed {
      logic load_req;     // capture the incoming request
      logic set_first;    // byte opens a new prefix
      logic start_scan;   // point the scan at the first free code
      logic rd;           // read the entry at the scan address
      logic advance;      // step the scan address
      logic take_hit;     // prefix becomes the matching code
      logic do_miss;      // emit prefix, insert pair, restart prefix
      logic emit_prefix;  // emit the final prefix
      logic emit_stop;    // emit stop code and restart the dictionary
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic prefix_valid;
      logic final_byte;
      logic scan_end;
      logic hit;
      logic out_free;
   } status_type;
endpackage

>>> rtl/lzw_encoder_12bit_core.sv
`timescale 1ns / 1ps
// Channel | Direction | Payload
// req_*   | in        | tdata[7:0] data_byte; tlast final_byte
// rsp_*   | out       | tdata[11:0] code_word, [15:12] zero; tlast run_last
//
// One request at a time. A request is captured in the idle state and decoded in
// the decide state; the search then walks the dictionary RAM from code 256 up to
// the next free code, one read and one compare per entry. A final byte also emits
// the final prefix and then the stop code. Reset is synchronous; the dictionary
// needs no clearing since only entries written since the last restart are
// searched. A stalled result holds in the output register and the controller
// waits before emitting more.
module lzw_encoder_12bit_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // final_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [11:0] code_word, [15:12] zero
   output logic        rsp_tlast    // run_last
);
   lzw_pkg::cmd_type              cmd;
   lzw_pkg::status_type           stat;
   logic [lzw_pkg::CODE_BITS-1:0] code;

   lzw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   lzw_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .in_byte   (req_tdata),
      .in_final  (req_tlast),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_code  (code),
      .out_last  (rsp_tlast)
   );

   // pad the code up to whole bytes
   assign rsp_tdata = {{(lzw_pkg::RSP_BITS-lzw_pkg::CODE_BITS){1'b0}}, code};
endmodule

>>> rtl/lzw_ram.sv
`timescale 1ns / 1ps
module lzw_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      if (re) rdata_ff <= mem[raddr];
   end
   assign rdata = rdata_ff;
endmodule

>>> rtl/lzw_ctrl.sv
`timescale 1ns / 1ps
module lzw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  lzw_pkg::status_type stat,
   output lzw_pkg::cmd_type    cmd
);
   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_RD     = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_MISS   = 3'd4;
   localparam logic [2:0] S_EPRE   = 3'd5;
   localparam logic [2:0] S_ESTOP  = 3'd6;

   logic [2:0] state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if (!stat.prefix_valid) begin
               cmd.set_first = 1'b1;
               state_in      = stat.final_byte ? S_EPRE : S_IDLE;
            end else begin
               cmd.start_scan = 1'b1;
               state_in       = S_RD;
            end
         end
         S_RD: begin
            if (stat.scan_end) begin
               state_in = S_MISS;
            end else begin
               cmd.rd   = 1'b1;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            if (stat.hit) begin
               cmd.take_hit = 1'b1;
               state_in     = stat.final_byte ? S_EPRE : S_IDLE;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_RD;
            end
         end
         S_MISS: begin
            if (stat.out_free) begin
               cmd.do_miss = 1'b1;
               state_in    = stat.final_byte ? S_EPRE : S_IDLE;
            end
         end
         S_EPRE: begin
            if (stat.out_free) begin
               cmd.emit_prefix = 1'b1;
               state_in        = S_ESTOP;
            end
         end
         S_ESTOP: begin
            if (stat.out_free) begin
               cmd.emit_stop = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule

>>> rtl/lzw_dpath.sv
`timescale 1ns / 1ps
module lzw_dpath (
   input  logic                                    clock,
   input  logic                                    reset,
   input  lzw_pkg::cmd_type                        cmd,
   output lzw_pkg::status_type                     stat,
   input  logic [lzw_pkg::BYTE_BITS-1:0]           in_byte,
   input  logic                                    in_final,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic [lzw_pkg::CODE_BITS-1:0]           out_code,
   output logic                                    out_last
);
   logic [lzw_pkg::CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                          pvalid_ff, pvalid_in;
   logic [lzw_pkg::CODE_BITS-1:0] free_ff, free_in;
   logic [lzw_pkg::CODE_BITS-1:0] addr_ff, addr_in;
   logic [lzw_pkg::BYTE_BITS-1:0] byte_ff;
   logic                          final_ff;
   logic                          ovalid_ff, ovalid_in;
   logic [lzw_pkg::CODE_BITS-1:0] ocode_ff, ocode_in;
   logic                          olast_ff, olast_in;
   logic [lzw_pkg::CODE_BITS-1:0] slot;
   logic [lzw_pkg::KEY_BITS-1:0]  key, rd_data;

   assign key  = {prefix_ff, byte_ff};
   // wrap the dictionary back to the first free code once it is full
   assign slot = (free_ff >= lzw_pkg::STOP_CODE) ? lzw_pkg::FIRST_FREE : free_ff;

   lzw_ram #(.WIDTH(lzw_pkg::KEY_BITS), .DEPTH(lzw_pkg::DICT_DEPTH)) u_dict (
      .clock (clock),
      .we    (cmd.do_miss),
      .waddr (slot),
      .wdata (key),
      .re    (cmd.rd),
      .raddr (addr_ff),
      .rdata (rd_data)
   );

   assign stat.prefix_valid = pvalid_ff;
   assign stat.final_byte   = final_ff;
   assign stat.scan_end     = (addr_ff >= free_ff);
   assign stat.hit          = (rd_data == key);
   assign stat.out_free     = !ovalid_ff || out_ready;

   always_comb begin
      prefix_in = prefix_ff;
      pvalid_in = pvalid_ff;
      free_in   = free_ff;
      addr_in   = addr_ff;
      ovalid_in = ovalid_ff && !out_ready;
      ocode_in  = ocode_ff;
      olast_in  = olast_ff;
      if (cmd.set_first) begin
         prefix_in = {{(lzw_pkg::CODE_BITS-lzw_pkg::BYTE_BITS){1'b0}}, byte_ff};
         pvalid_in = 1'b1;
      end
      if (cmd.start_scan) addr_in = lzw_pkg::FIRST_FREE;
      if (cmd.advance)    addr_in = addr_ff + 1'b1;
      if (cmd.take_hit)   prefix_in = addr_ff;
      if (cmd.do_miss) begin
         ovalid_in = 1'b1;
         ocode_in  = prefix_ff;
         olast_in  = !final_ff;
         free_in   = slot + 1'b1;
         prefix_in = {{(lzw_pkg::CODE_BITS-lzw_pkg::BYTE_BITS){1'b0}}, byte_ff};
      end
      if (cmd.emit_prefix) begin
         ovalid_in = 1'b1;
         ocode_in  = prefix_ff;
         olast_in  = 1'b0;
      end
      if (cmd.emit_stop) begin
         ovalid_in = 1'b1;
         ocode_in  = lzw_pkg::STOP_CODE;
         olast_in  = 1'b1;
         prefix_in = '0;
         pvalid_in = 1'b0;
         free_in   = lzw_pkg::FIRST_FREE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         pvalid_ff <= 1'b0;
         free_ff   <= lzw_pkg::FIRST_FREE;
         ovalid_ff <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         pvalid_ff <= pvalid_in;
         free_ff   <= free_in;
         ovalid_ff <= ovalid_in;
      end
      addr_ff  <= addr_in;
      ocode_ff <= ocode_in;
      olast_ff <= olast_in;
      if (cmd.load_req) begin
         byte_ff  <= in_byte;
         final_ff <= in_final;
      end
   end

   assign out_valid = ovalid_ff;
   assign out_code  = ocode_ff;
   assign out_last  = olast_ff;
endmodule

>>> rtl/lzw_checker.sv
`timescale 1ns / 1ps
module lzw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast
);
   // a held result must not change
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[15:12] == 4'd0)
      else $error("padding bits set");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while busy");

   a_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[11:0] == lzw_pkg::STOP_CODE |-> rsp_tlast)
      else $error("stop code not last");
endmodule

bind lzw_encoder_12bit_core lzw_checker u_checker (.*);
